@@ design/imu_fbd_pkg.sv @@
// Shared constants and types for the IMU frame block decoder.
package imu_fbd_pkg;

  localparam int unsigned IDX_W = 6;

  localparam logic [IDX_W-1:0] FIRST_SUM_END   = IDX_W'(10);
  localparam logic [IDX_W-1:0] ACCEL_TYPE_IDX  = IDX_W'(1);
  localparam logic [IDX_W-1:0] ACCEL_LO_IDX    = IDX_W'(2);
  localparam logic [IDX_W-1:0] ACCEL_HI_IDX    = IDX_W'(7);
  localparam logic [IDX_W-1:0] SECOND_LO_IDX   = IDX_W'(22);
  localparam logic [IDX_W-1:0] ANGLE_TYPE_IDX  = IDX_W'(23);
  localparam logic [IDX_W-1:0] ANGLE_LO_IDX    = IDX_W'(24);
  localparam logic [IDX_W-1:0] ANGLE_HI_IDX    = IDX_W'(29);
  localparam logic [IDX_W-1:0] SECOND_SUM_END  = IDX_W'(31);
  localparam logic [IDX_W-1:0] LAST_IDX        = IDX_W'(32);
  localparam logic [IDX_W-1:0] IDLE_IDX        = IDX_W'(33);

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] ACCEL_TYPE  = 8'h51;
  localparam logic [7:0] ANGLE_TYPE  = 8'h53;

  // 360 degrees in angle units
  localparam logic signed [17:0] FULL_TURN = 18'sd65536;

  typedef struct packed {
    logic               accel_updated;
    logic               angle_updated;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic        [16:0] yaw_angle;
  } res_t;

endpackage

@@ design/imu_fbd_if.sv @@
// Handshake channels for the byte input and the decoded result.
interface imu_fbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface imu_fbd_out_if;
  logic               valid;
  logic               ready;
  logic               accel_updated;
  logic               angle_updated;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic        [16:0] yaw_angle;

  modport source (output valid, output accel_updated, output angle_updated,
                  output accel_x, output accel_y, output accel_z,
                  output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink   (input valid, input accel_updated, input angle_updated,
                  input accel_x, input accel_y, input accel_z,
                  input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

@@ design/imu_fbd_in_stage.sv @@
// Input register stage: captures one byte request from the input channel.
module imu_fbd_in_stage (
  input  logic           clk,
  input  logic           rst,
  imu_fbd_in_if.sink     byte_in,
  input  logic           advance,
  output logic           stg_valid,
  output logic [7:0]     stg_byte,
  output logic           stg_start
);

  // accept whenever the stage is empty or drains this cycle
  assign byte_in.ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (byte_in.ready) begin
      stg_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      stg_byte  <= byte_in.data_byte;
      stg_start <= byte_in.block_start;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !advance) |=> stg_valid)
    else $error("in_stage: held byte dropped");

  assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !advance) |=> ($stable(stg_byte) && $stable(stg_start)))
    else $error("in_stage: held byte overwritten");

  assert property (@(posedge clk) disable iff (rst)
    advance |-> stg_valid)
    else $error("in_stage: advance with empty stage");

endmodule

@@ design/imu_fbd_frame.sv @@
// Frame tracker: byte index, checksums, captures and held sensor values.
module imu_fbd_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [7:0]          data_byte,
  input  logic                block_start,
  input  logic [15:0]         yaw_offset,
  output logic                produce,
  output imu_fbd_pkg::res_t   res_next
);

  logic [imu_fbd_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [imu_fbd_pkg::IDX_W-1:0] idx;
  logic        header_ok, header_ok_next;
  logic [7:0]  first_sum, first_sum_next;
  logic [7:0]  second_sum, second_sum_next;
  logic [7:0]  first_type, first_type_next;
  logic [7:0]  second_type, second_type_next;
  logic [47:0] pend_accel, pend_accel_next;
  logic [47:0] pend_angle, pend_angle_next;
  logic [47:0] held_accel, held_accel_next;
  logic [31:0] held_roll_pitch, held_roll_pitch_next;
  logic [16:0] held_yaw, held_yaw_next;
  logic        acc_ok, ang_ok;
  logic [7:0]  second_sum_fin;
  logic signed [17:0] yaw_sum;
  logic signed [17:0] yaw_wrap;
  logic [2:0]  accel_slot, angle_slot;

  assign idx = block_start ? '0 : byte_index;
  assign accel_slot = 3'(idx - imu_fbd_pkg::ACCEL_LO_IDX);
  assign angle_slot = 3'(idx - imu_fbd_pkg::ANGLE_LO_IDX);

  // frame checks on the last byte
  assign second_sum_fin = second_sum - data_byte;
  assign acc_ok = header_ok && (first_sum == 8'd0) &&
                  (first_type == imu_fbd_pkg::ACCEL_TYPE);
  assign ang_ok = header_ok && (second_sum_fin == 8'd0) &&
                  (second_type == imu_fbd_pkg::ANGLE_TYPE);

  // yaw plus offset, wrapped once into 0..65536
  assign yaw_sum = 18'(signed'(pend_angle[47:32])) + signed'({2'b00, yaw_offset});
  always_comb begin
    if (yaw_sum > imu_fbd_pkg::FULL_TURN) begin
      yaw_wrap = yaw_sum - imu_fbd_pkg::FULL_TURN;
    end else if (yaw_sum < 18'sd0) begin
      yaw_wrap = yaw_sum + imu_fbd_pkg::FULL_TURN;
    end else begin
      yaw_wrap = yaw_sum;
    end
  end

  // next state per byte position
  always_comb begin
    header_ok_next       = header_ok;
    first_sum_next       = first_sum;
    second_sum_next      = second_sum;
    first_type_next      = first_type;
    second_type_next     = second_type;
    pend_accel_next      = pend_accel;
    pend_angle_next      = pend_angle;
    held_accel_next      = held_accel;
    held_roll_pitch_next = held_roll_pitch;
    held_yaw_next        = held_yaw;
    produce              = 1'b0;

    if (idx == '0) begin
      header_ok_next  = (data_byte == imu_fbd_pkg::HEADER_BYTE);
      first_sum_next  = data_byte;
      second_sum_next = 8'd0;
    end else if (idx < imu_fbd_pkg::FIRST_SUM_END) begin
      first_sum_next = first_sum + data_byte;
      if (idx == imu_fbd_pkg::ACCEL_TYPE_IDX) begin
        first_type_next = data_byte;
      end
      if (idx >= imu_fbd_pkg::ACCEL_LO_IDX && idx <= imu_fbd_pkg::ACCEL_HI_IDX) begin
        pend_accel_next[accel_slot*8 +: 8] = data_byte;
      end
    end else if (idx == imu_fbd_pkg::FIRST_SUM_END) begin
      first_sum_next = first_sum - data_byte;
    end else if (idx >= imu_fbd_pkg::SECOND_LO_IDX &&
                 idx <= imu_fbd_pkg::SECOND_SUM_END) begin
      second_sum_next = second_sum + data_byte;
      if (idx == imu_fbd_pkg::ANGLE_TYPE_IDX) begin
        second_type_next = data_byte;
      end
      if (idx >= imu_fbd_pkg::ANGLE_LO_IDX && idx <= imu_fbd_pkg::ANGLE_HI_IDX) begin
        pend_angle_next[angle_slot*8 +: 8] = data_byte;
      end
    end else if (idx == imu_fbd_pkg::LAST_IDX) begin
      second_sum_next = second_sum_fin;
      produce         = 1'b1;
      if (acc_ok) begin
        held_accel_next = pend_accel;
      end
      if (ang_ok) begin
        held_roll_pitch_next = pend_angle[31:0];
        held_yaw_next        = yaw_wrap[16:0];
      end
    end
  end

  assign byte_index_next = (idx < imu_fbd_pkg::IDLE_IDX) ?
                           idx + 1'b1 : imu_fbd_pkg::IDLE_IDX;

  // result fields as seen after this byte
  always_comb begin
    res_next.accel_updated = acc_ok;
    res_next.angle_updated = ang_ok;
    res_next.accel_x       = held_accel_next[15:0];
    res_next.accel_y       = held_accel_next[31:16];
    res_next.accel_z       = held_accel_next[47:32];
    res_next.roll_angle    = held_roll_pitch_next[15:0];
    res_next.pitch_angle   = held_roll_pitch_next[31:16];
    res_next.yaw_angle     = held_yaw_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      header_ok       <= 1'b0;
      first_sum       <= '0;
      second_sum      <= '0;
      first_type      <= '0;
      second_type     <= '0;
      pend_accel      <= '0;
      pend_angle      <= '0;
      held_accel      <= '0;
      held_roll_pitch <= '0;
      held_yaw        <= '0;
    end else if (go) begin
      byte_index      <= byte_index_next;
      header_ok       <= header_ok_next;
      first_sum       <= first_sum_next;
      second_sum      <= second_sum_next;
      first_type      <= first_type_next;
      second_type     <= second_type_next;
      pend_accel      <= pend_accel_next;
      pend_angle      <= pend_angle_next;
      held_accel      <= held_accel_next;
      held_roll_pitch <= held_roll_pitch_next;
      held_yaw        <= held_yaw_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    byte_index <= imu_fbd_pkg::IDLE_IDX)
    else $error("frame: byte index past idle");

  assert property (@(posedge clk) disable iff (rst)
    (go && produce) |=> (byte_index == imu_fbd_pkg::IDLE_IDX))
    else $error("frame: index not parked after last byte");

  assert property (@(posedge clk) disable iff (rst)
    held_yaw <= 17'd65536)
    else $error("frame: yaw out of range");

  assert property (@(posedge clk) disable iff (rst)
    !go |=> ($stable(held_accel) && $stable(held_yaw) && $stable(byte_index)))
    else $error("frame: state moved without a byte");

endmodule

@@ design/imu_frame_block_decoder_core.sv @@
// Top level: input stage, frame tracker, offset register and result register.
// Result path: the last byte of a block (block byte 32) passes the input register, then the result register.
// Throughput: one byte per cycle while no result is stalled; only byte 32 of a block yields a result request.
// While a result waits on a stalled receiver the tracker holds, one more byte waits in
// the input register, and then the input stalls.
// Synchronous active-high reset clears the index, sums, held values and offset to zero.
module imu_frame_block_decoder_core (
  input  logic           clk,
  input  logic           rst,
  imu_fbd_in_if.sink     byte_in,
  imu_fbd_out_if.source  result_out,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata
);

  logic               stg_valid;
  logic [7:0]         stg_byte;
  logic               stg_start;
  logic               out_free;
  logic               go;
  logic               produce;
  logic [15:0]        yaw_offset;
  logic               out_valid;
  imu_fbd_pkg::res_t  res_next;
  imu_fbd_pkg::res_t  res;

  assign out_free = !out_valid || result_out.ready;
  assign go       = stg_valid && out_free;

  imu_fbd_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .advance   (go),
    .stg_valid (stg_valid),
    .stg_byte  (stg_byte),
    .stg_start (stg_start)
  );

  imu_fbd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .data_byte   (stg_byte),
    .block_start (stg_start),
    .yaw_offset  (yaw_offset),
    .produce     (produce),
    .res_next    (res_next)
  );

  // yaw offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_offset <= '0;
    end else if (cfg_we) begin
      yaw_offset <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && produce) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && produce) begin
      res <= res_next;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.accel_updated = res.accel_updated;
  assign result_out.angle_updated = res.angle_updated;
  assign result_out.accel_x       = res.accel_x;
  assign result_out.accel_y       = res.accel_y;
  assign result_out.accel_z       = res.accel_z;
  assign result_out.roll_angle    = res.roll_angle;
  assign result_out.pitch_angle   = res.pitch_angle;
  assign result_out.yaw_angle     = res.yaw_angle;

  assert property (@(posedge clk) disable iff (rst)
    !(go && produce && out_valid && !result_out.ready))
    else $error("core: result overwrote a waiting request");

  assert property (@(posedge clk) disable iff (rst)
    (go && produce) |=> out_valid)
    else $error("core: result lost");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_out.ready) |-> !go)
    else $error("core: byte processed while result blocked");

endmodule

@@ verif/imu_fbd_checker.sv @@
// Checker for the IMU frame block decoder: watches both channels, predicts and compares results.
module imu_fbd_checker (
  input  logic          clk,
  input  logic          rst,
  imu_fbd_in_if         in_ch,
  imu_fbd_out_if        out_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  output int            fail_count,
  output int            open_results,
  output int            results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state, mirrors the block's own registers
  logic [imu_fbd_pkg::IDX_W-1:0] blk_idx;
  logic             hdr_seen;
  logic [7:0]       accel_sum;
  logic [7:0]       angle_sum;
  logic [7:0]       accel_kind;
  logic [7:0]       angle_kind;
  logic [47:0]      accel_raw;
  logic [47:0]      angle_raw;
  logic [47:0]      accel_hold;
  logic [31:0]      rp_hold;
  logic [16:0]      yaw_hold;
  logic [15:0]      yaw_bias;

  imu_fbd_pkg::res_t decoded_q[$];
  int   fails = 0;
  int   seen = 0;

  assign fail_count   = fails;
  assign results_seen = seen;

  // one byte through the frame tracker; returns 1 when it closes a block
  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output imu_fbd_pkg::res_t r);
    logic [imu_fbd_pkg::IDX_W-1:0] idx;
    bit               ok_a;
    bit               ok_g;
    int               yaw;
    idx = start ? '0 : blk_idx;
    r = '0;
    decode_byte = 1'b0;
    if (idx == '0) begin
      hdr_seen  = (b == imu_fbd_pkg::HEADER_BYTE);
      accel_sum = b;
      angle_sum = 8'h00;
    end else if (idx < imu_fbd_pkg::FIRST_SUM_END) begin
      accel_sum = accel_sum + b;
      if (idx == imu_fbd_pkg::ACCEL_TYPE_IDX) accel_kind = b;
      if (idx >= imu_fbd_pkg::ACCEL_LO_IDX && idx <= imu_fbd_pkg::ACCEL_HI_IDX)
        accel_raw[(idx - imu_fbd_pkg::ACCEL_LO_IDX) * 8 +: 8] = b;
    end else if (idx == imu_fbd_pkg::FIRST_SUM_END) begin
      accel_sum = accel_sum - b;
    end else if (idx >= imu_fbd_pkg::SECOND_LO_IDX && idx <= imu_fbd_pkg::SECOND_SUM_END) begin
      angle_sum = angle_sum + b;
      if (idx == imu_fbd_pkg::ANGLE_TYPE_IDX) angle_kind = b;
      if (idx >= imu_fbd_pkg::ANGLE_LO_IDX && idx <= imu_fbd_pkg::ANGLE_HI_IDX)
        angle_raw[(idx - imu_fbd_pkg::ANGLE_LO_IDX) * 8 +: 8] = b;
    end else if (idx == imu_fbd_pkg::LAST_IDX) begin
      angle_sum = angle_sum - b;
      ok_a = hdr_seen && accel_sum == 8'h00 && accel_kind == imu_fbd_pkg::ACCEL_TYPE;
      ok_g = hdr_seen && angle_sum == 8'h00 && angle_kind == imu_fbd_pkg::ANGLE_TYPE;
      if (ok_a) accel_hold = accel_raw;
      if (ok_g) begin
        rp_hold = angle_raw[31:0];
        // offset add, then a single wrap into 0..full turn
        yaw = int'($signed(angle_raw[47:32])) + int'(yaw_bias);
        if (yaw > int'(imu_fbd_pkg::FULL_TURN)) yaw = yaw - int'(imu_fbd_pkg::FULL_TURN);
        else if (yaw < 0) yaw = yaw + int'(imu_fbd_pkg::FULL_TURN);
        yaw_hold = yaw[16:0];
      end
      r.accel_updated = ok_a;
      r.angle_updated = ok_g;
      r.accel_x       = accel_hold[15:0];
      r.accel_y       = accel_hold[31:16];
      r.accel_z       = accel_hold[47:32];
      r.roll_angle    = rp_hold[15:0];
      r.pitch_angle   = rp_hold[31:16];
      r.yaw_angle     = yaw_hold;
      decode_byte = 1'b1;
    end
    blk_idx = (idx < imu_fbd_pkg::IDLE_IDX) ? idx + 1'b1 : imu_fbd_pkg::IDLE_IDX;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // track requests on both channels at each rising edge
  always @(posedge clk) begin
    imu_fbd_pkg::res_t nxt;
    imu_fbd_pkg::res_t want;
    if (rst) begin
      blk_idx    = '0;
      hdr_seen   = 1'b0;
      accel_sum  = '0;
      angle_sum  = '0;
      accel_kind = '0;
      angle_kind = '0;
      accel_raw  = '0;
      angle_raw  = '0;
      accel_hold = '0;
      rp_hold    = '0;
      yaw_hold   = '0;
      yaw_bias   = '0;
      decoded_q.delete();
    end else begin
      if (cfg_we) yaw_bias = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        if (decode_byte(in_ch.data_byte, in_ch.block_start, nxt)) decoded_q.push_back(nxt);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen++;
        if (decoded_q.size() == 0) begin
          $error("result request with no decoded block waiting");
          fails++;
        end else begin
          want = decoded_q.pop_front();
          compare_field("accel_updated", int'(want.accel_updated), int'(out_ch.accel_updated));
          compare_field("angle_updated", int'(want.angle_updated), int'(out_ch.angle_updated));
          compare_field("accel_x", int'(want.accel_x), int'(out_ch.accel_x));
          compare_field("accel_y", int'(want.accel_y), int'(out_ch.accel_y));
          compare_field("accel_z", int'(want.accel_z), int'(out_ch.accel_z));
          compare_field("roll_angle", int'(want.roll_angle), int'(out_ch.roll_angle));
          compare_field("pitch_angle", int'(want.pitch_angle), int'(out_ch.pitch_angle));
          compare_field("yaw_angle", int'(want.yaw_angle), int'(out_ch.yaw_angle));
        end
      end
    end
    open_results = decoded_q.size();
  end

endmodule

@@ verif/imu_frame_block_decoder_core_tb.sv @@
// Testbench top for the IMU frame block decoder: clock, reset, byte stimulus and verdict.
module imu_frame_block_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_BYTES = int'(imu_fbd_pkg::LAST_IDX) + 1;
  localparam int QUIET_LIMIT = 2000;

  // block fault masks
  localparam int NO_FAULT       = 0;
  localparam int BAD_HEADER     = 1;
  localparam int BAD_ACCEL_TYPE = 2;
  localparam int BAD_ACCEL_SUM  = 4;
  localparam int BAD_ANGLE_TYPE = 8;
  localparam int BAD_ANGLE_SUM  = 16;
  localparam int ALL_FAULTS     = 31;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int fail_count;
  int open_results;
  int results_seen;
  int item_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit calm = 1'b0;
  int quiet = 0;

  imu_fbd_in_if  in_ch ();
  imu_fbd_out_if out_ch ();

  imu_frame_block_decoder_core uut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (in_ch),
    .result_out (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  imu_fbd_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .open_results (open_results),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: too long without any accepted request ends the run
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("** imu_frame_block_decoder_core: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random stall bursts plus one long hold to back up the input
  initial begin
    int  hold;
    bit  long_done;
    hold = 0;
    long_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && results_seen >= 6) begin
        hold = 240;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(16, 1) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one byte request; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic s);
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.block_start <= s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // build a block from six motion words (ax ay az roll pitch yaw) and send its first len bytes
  task automatic send_block(input logic [15:0] w [6], input int faults, input int len,
                            input bit with_start);
    logic [7:0] blk [BLOCK_BYTES];
    logic [7:0] s1;
    logic [7:0] s2;
    for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = 8'($urandom);
    blk[0] = imu_fbd_pkg::HEADER_BYTE ^
             ((faults & BAD_HEADER) ? 8'($urandom_range(255, 1)) : 8'h00);
    blk[imu_fbd_pkg::ACCEL_TYPE_IDX] = imu_fbd_pkg::ACCEL_TYPE ^
        ((faults & BAD_ACCEL_TYPE) ? 8'($urandom_range(255, 1)) : 8'h00);
    for (int k = 0; k < 3; k++) begin
      blk[int'(imu_fbd_pkg::ACCEL_LO_IDX) + 2 * k]     = w[k][7:0];
      blk[int'(imu_fbd_pkg::ACCEL_LO_IDX) + 2 * k + 1] = w[k][15:8];
    end
    if ($urandom_range(3) != 0) blk[imu_fbd_pkg::SECOND_LO_IDX] = imu_fbd_pkg::HEADER_BYTE;
    blk[imu_fbd_pkg::ANGLE_TYPE_IDX] = imu_fbd_pkg::ANGLE_TYPE ^
        ((faults & BAD_ANGLE_TYPE) ? 8'($urandom_range(255, 1)) : 8'h00);
    for (int k = 0; k < 3; k++) begin
      blk[int'(imu_fbd_pkg::ANGLE_LO_IDX) + 2 * k]     = w[k + 3][7:0];
      blk[int'(imu_fbd_pkg::ANGLE_LO_IDX) + 2 * k + 1] = w[k + 3][15:8];
    end
    s1 = '0;
    for (int i = 0; i < int'(imu_fbd_pkg::FIRST_SUM_END); i++) s1 = s1 + blk[i];
    blk[imu_fbd_pkg::FIRST_SUM_END] = s1 ^
        ((faults & BAD_ACCEL_SUM) ? 8'($urandom_range(255, 1)) : 8'h00);
    s2 = '0;
    for (int i = int'(imu_fbd_pkg::SECOND_LO_IDX); i < int'(imu_fbd_pkg::LAST_IDX); i++)
      s2 = s2 + blk[i];
    blk[imu_fbd_pkg::LAST_IDX] = s2 ^
        ((faults & BAD_ANGLE_SUM) ? 8'($urandom_range(255, 1)) : 8'h00);
    for (int i = 0; i < len; i++) begin
      send_byte(blk[i], (i == 0) && with_start);
      item_count++;
    end
  endtask

  // stray bytes; without a start flag they fall past the end of a block
  task automatic send_noise(input int n, input bit may_start);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), may_start && ($urandom_range(9) == 0));
  endtask

  // offset write once the block has drained
  task automatic write_yaw_bias(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // main stimulus
  initial begin
    logic [15:0] w [6];
    int          r;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.block_start = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first block after reset without a start flag, offset still at reset value
    send_block('{16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000},
               NO_FAULT, BLOCK_BYTES, 1'b0);
    send_noise(3, 1'b0);
    send_block('{16'hFFFF, 16'h0001, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF},
               NO_FAULT, BLOCK_BYTES, 1'b1);
    send_block('{16'h1234, 16'h5678, 16'h9ABC, 16'h1111, 16'h2222, 16'h3333},
               BAD_HEADER, BLOCK_BYTES, 1'b1);
    // start in mid-block drops the partial block
    send_block('{16'h4444, 16'h5555, 16'h6666, 16'h7777, 16'h0101, 16'h0202},
               NO_FAULT, 15, 1'b1);
    send_block('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
               NO_FAULT, BLOCK_BYTES, 1'b1);
    send_block('{16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333, 16'hF0F0, 16'h0F0F},
               BAD_ACCEL_TYPE, BLOCK_BYTES, 1'b1);
    send_block('{16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'h5555, 16'hAAAA},
               BAD_ANGLE_SUM, BLOCK_BYTES, 1'b1);
    send_block('{16'h8001, 16'h7FFE, 16'h0002, 16'hFFFE, 16'h0003, 16'h0004},
               BAD_ACCEL_SUM | BAD_ANGLE_TYPE, BLOCK_BYTES, 1'b1);

    // largest offset: yaw lands exactly on a full turn, then past it
    write_yaw_bias(16'hFFFF);
    send_block('{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0001},
               NO_FAULT, BLOCK_BYTES, 1'b1);
    send_block('{16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h7FFF},
               NO_FAULT, BLOCK_BYTES, 1'b1);
    send_block('{16'h000B, 16'h000C, 16'h000D, 16'h000E, 16'h000F, 16'h8000},
               NO_FAULT, BLOCK_BYTES, 1'b1);
    write_yaw_bias(16'h8000);
    send_block('{16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h8000},
               NO_FAULT, BLOCK_BYTES, 1'b1);

    // random phases, each with its own offset and idling mix
    while (item_count < 1000) begin
      case ($urandom_range(7))
        0:       write_yaw_bias(16'h0000);
        1:       write_yaw_bias(16'hFFFF);
        2:       write_yaw_bias(16'h0001);
        default: write_yaw_bias(16'($urandom));
      endcase
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 40;
      endcase
      case ($urandom_range(2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 40;
      endcase
      if (item_count >= 850) calm = 1'b1;
      repeat (6) begin
        for (int k = 0; k < 6; k++) w[k] = pick_word();
        r = $urandom_range(99);
        if (r < 8) begin
          send_noise($urandom_range(6, 1), 1'b1);
        end else if (r < 14) begin
          send_block(w, NO_FAULT, $urandom_range(BLOCK_BYTES - 1, 1), 1'b1);
        end else if (r < 80) begin
          send_block(w, NO_FAULT, BLOCK_BYTES, 1'b1);
        end else begin
          send_block(w, $urandom_range(ALL_FAULTS, 1), BLOCK_BYTES, 1'b1);
        end
      end
    end

    // drain, then allow for the block's latency
    in_ch.valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("** imu_frame_block_decoder_core: PASSED **");
    end else begin
      $display("** imu_frame_block_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/imu_fbd_pkg.sv
design/imu_fbd_if.sv
design/imu_fbd_in_stage.sv
design/imu_fbd_frame.sv
design/imu_frame_block_decoder_core.sv
verif/imu_fbd_checker.sv
verif/imu_frame_block_decoder_core_tb.sv
